// ===== hw/rtl/pbsu_pkg.sv =====
// shared types and constants of the packed bitmap slice unpacker
`default_nettype none

package pbsu_pkg;

  // configuration register indexes, one 32-bit word each
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_PIXEL_MODE   = 3'd2,
    REG_SLICE_COUNT  = 3'd3,
    REG_SLICE_INDEX  = 3'd4,
    REG_ORIGIN_X     = 3'd5,
    REG_ORIGIN_Y     = 3'd6
  } cfg_reg_e;

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // pixel packing modes
  localparam logic [1:0] Mode1Bpp = 2'd1;
  localparam logic [1:0] Mode2Bpp = 2'd2;

  localparam int unsigned CoordW     = 17;
  localparam int unsigned PixPerByte = 8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned OutDataW   = 40;

  typedef struct packed {
    logic [7:0]  image_width;
    logic [7:0]  image_height;
    logic [1:0]  pixel_mode;
    logic [7:0]  slice_count;
    logic [7:0]  slice_index;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } cfg_t;

  // one classified byte: pixels to draw and where
  typedef struct packed {
    logic                    bad;
    logic [PixPerByte-1:0]   draw;
    logic [PixPerByte-1:0]   black;
    logic [CoordW-1:0]       x_base;
    logic [CoordW-1:0]       y;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/packed_bitmap_slice_unpacker.sv =====
// Packed bitmap slice unpacker top level. The front end takes each image
// byte, works out the pixels it draws and queues them (four bytes deep); the
// back end sends one pixel word per cycle while the output is ready, so
// a byte that draws n pixels gives n words (1 to 8; a full one-bit-per-pixel
// byte gives 8) and a byte that draws nothing is not queued. With an invalid
// configuration every byte gives one word flagged in tuser. Registers are to
// be written over the APB port while no byte is in flight (not enforced).
`default_nettype none

module packed_bitmap_slice_unpacker #(
  parameter int unsigned MAX_ROW_BYTES = 64
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [pbsu_pkg::ApbAddrW-1:0]     paddr,
  input  wire  [pbsu_pkg::ApbDataW-1:0]     pwdata,
  output logic [pbsu_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  // byte input
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [7:0]                        s_axis_tdata,   // data_byte
  // pixel output
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [pbsu_pkg::OutDataW-1:0]     m_axis_tdata,   // pixel_x, pixel_y, pixel_black
  output logic                              m_axis_tuser,   // bad_config
  output logic                              m_axis_tlast    // last_of_byte
);

  pbsu_pkg::cfg_t   cfg_q;
  pbsu_pkg::entry_t push_entry;
  pbsu_pkg::entry_t pop_entry;
  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  logic [pbsu_pkg::CoordW-1:0] px, py;
  logic             pblack;
  logic [2:0]       reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        pbsu_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[7:0];
        pbsu_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[7:0];
        pbsu_pkg::REG_PIXEL_MODE:   cfg_q.pixel_mode   <= pwdata[1:0];
        pbsu_pkg::REG_SLICE_COUNT:  cfg_q.slice_count  <= pwdata[7:0];
        pbsu_pkg::REG_SLICE_INDEX:  cfg_q.slice_index  <= pwdata[7:0];
        pbsu_pkg::REG_ORIGIN_X:     cfg_q.origin_x     <= pwdata[15:0];
        pbsu_pkg::REG_ORIGIN_Y:     cfg_q.origin_y     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      pbsu_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_q.image_width);
      pbsu_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_q.image_height);
      pbsu_pkg::REG_PIXEL_MODE:   prdata = 32'(cfg_q.pixel_mode);
      pbsu_pkg::REG_SLICE_COUNT:  prdata = 32'(cfg_q.slice_count);
      pbsu_pkg::REG_SLICE_INDEX:  prdata = 32'(cfg_q.slice_index);
      pbsu_pkg::REG_ORIGIN_X:     prdata = 32'(cfg_q.origin_x);
      pbsu_pkg::REG_ORIGIN_Y:     prdata = 32'(cfg_q.origin_y);
      default:                    prdata = '0;
    endcase
  end

  pbsu_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_data_i    (s_axis_tdata),
    .in_ready_o   (s_axis_tready),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  pbsu_fifo #(
    .WIDTH ($bits(pbsu_pkg::entry_t)),
    .DEPTH (pbsu_pkg::QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  pbsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .out_valid_o (m_axis_tvalid),
    .out_x_o     (px),
    .out_y_o     (py),
    .out_black_o (pblack),
    .out_bad_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {5'b00000, pblack, py, px};

endmodule

`default_nettype wire

// ===== hw/rtl/pbsu_front.sv =====
// front end: takes bytes, tracks row position, builds pixel masks
`default_nettype none

module pbsu_front #(
  parameter int unsigned MAX_ROW_BYTES = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  pbsu_pkg::cfg_t    cfg_i,
  input  wire               in_valid_i,
  input  wire  [7:0]        in_data_i,
  output logic              in_ready_o,
  output logic              push_valid_o,
  output pbsu_pkg::entry_t  push_entry_o,
  input  wire               push_ready_i
);

  localparam int unsigned BW   = $clog2(MAX_ROW_BYTES);
  localparam int unsigned ColW = (BW + 3 > 8) ? BW + 3 : 8;

  logic [BW-1:0] byte_in_row_q, byte_in_row_d;
  logic [7:0]    row_number_q, row_number_d;

  logic [5:0]    row_bytes;
  logic [6:0]    stride;
  logic          cfg_ok;
  logic          in_row;
  logic [ColW-1:0] base;
  logic [ColW-1:0] col;
  logic [pbsu_pkg::PixPerByte-1:0] draw;
  logic [pbsu_pkg::PixPerByte-1:0] black;
  logic          accept;
  logic          row_end;

  // row stride and configuration check
  always_comb begin
    row_bytes = 6'((9'(cfg_i.image_width) + 9'd7) >> 3);
    stride    = (cfg_i.pixel_mode == pbsu_pkg::Mode2Bpp) ? {row_bytes, 1'b0}
                                                          : {1'b0, row_bytes};
    cfg_ok    = ((cfg_i.pixel_mode == pbsu_pkg::Mode1Bpp) ||
                 (cfg_i.pixel_mode == pbsu_pkg::Mode2Bpp)) &&
                (cfg_i.image_width != 8'd0) && (cfg_i.image_height != 8'd0) &&
                (cfg_i.slice_index < cfg_i.slice_count) &&
                (stride != 7'd0) && (int'(stride) <= int'(MAX_ROW_BYTES));
  end

  // pixel masks of the incoming byte
  always_comb begin
    in_row = 8'(byte_in_row_q) < 8'(stride);
    if (cfg_i.pixel_mode == pbsu_pkg::Mode1Bpp) begin
      base = ColW'({byte_in_row_q, 3'b000});
    end else begin
      base = ColW'({byte_in_row_q, 2'b00});
    end
    draw  = '0;
    black = '0;
    col   = '0;
    for (int k = 0; k < 8; k++) begin
      col = base + ColW'(k);
      if (cfg_i.pixel_mode == pbsu_pkg::Mode1Bpp) begin
        draw[k]  = col < ColW'(cfg_i.image_width);
        black[k] = in_data_i[7-k];
      end else if (k < 4) begin
        draw[k]  = (col < ColW'(cfg_i.image_width)) && !in_data_i[7-2*k];
        black[k] = in_data_i[6-2*k];
      end
    end
    if (!in_row) begin
      draw = '0;
    end
  end

  // queue entry; a bad configuration gives one blank result
  always_comb begin
    if (!cfg_ok) begin
      push_entry_o.bad    = 1'b1;
      push_entry_o.draw   = pbsu_pkg::PixPerByte'(1);
      push_entry_o.black  = '0;
      push_entry_o.x_base = '0;
      push_entry_o.y      = '0;
    end else begin
      push_entry_o.bad    = 1'b0;
      push_entry_o.draw   = draw;
      push_entry_o.black  = black;
      push_entry_o.x_base = {cfg_i.origin_x[15], cfg_i.origin_x} +
                            pbsu_pkg::CoordW'(base);
      push_entry_o.y      = {cfg_i.origin_y[15], cfg_i.origin_y} +
                            pbsu_pkg::CoordW'(row_number_q);
    end
  end

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;
  assign push_valid_o = in_valid_i && (push_entry_o.bad || (push_entry_o.draw != '0));

  // position counters
  always_comb begin
    byte_in_row_d = byte_in_row_q;
    row_number_d  = row_number_q;
    row_end       = (8'(byte_in_row_q) + 8'd1) >= 8'(stride);
    if (accept && cfg_ok) begin
      if (row_end) begin
        byte_in_row_d = '0;
        if ((9'(row_number_q) + 9'd1) >= 9'(cfg_i.image_height)) begin
          row_number_d = '0;
        end else begin
          row_number_d = row_number_q + 8'd1;
        end
      end else begin
        byte_in_row_d = byte_in_row_q + BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_in_row_q <= '0;
      row_number_q  <= '0;
    end else begin
      byte_in_row_q <= byte_in_row_d;
      row_number_q  <= row_number_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pbsu_fifo.sv =====
// small first-in first-out queue between front and back
`default_nettype none

module pbsu_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_valid_i,
  input  wire  [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  wire              pop_ready_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = count_q != CntW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointer and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pbsu_back.sv =====
// back end: walks the pixel mask of one byte, one pixel word per cycle while the output is ready
`default_nettype none

module pbsu_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          pop_valid_i,
  input  pbsu_pkg::entry_t             pop_entry_i,
  output logic                         pop_ready_o,
  output logic                         out_valid_o,
  output logic [pbsu_pkg::CoordW-1:0]  out_x_o,
  output logic [pbsu_pkg::CoordW-1:0]  out_y_o,
  output logic                         out_black_o,
  output logic                         out_bad_o,
  output logic                         out_last_o,
  input  wire                          out_ready_i
);

  localparam int unsigned KW = $clog2(pbsu_pkg::PixPerByte);

  pbsu_pkg::entry_t cur_q, cur_d;
  logic             cur_valid_q, cur_valid_d;
  logic             out_valid_q, out_valid_d;
  logic [pbsu_pkg::CoordW-1:0] out_x_q, out_y_q;
  logic             out_black_q, out_bad_q, out_last_q;

  logic [KW-1:0]    k_idx;
  logic [pbsu_pkg::PixPerByte-1:0] rest;
  logic             last;
  logic             out_load;
  logic             cur_free;

  // lowest pixel still to send
  always_comb begin
    k_idx = '0;
    for (int k = pbsu_pkg::PixPerByte - 1; k >= 0; k--) begin
      if (cur_q.draw[k]) begin
        k_idx = KW'(k);
      end
    end
    rest = cur_q.draw;
    rest[k_idx] = 1'b0;
    last = rest == '0;
  end

  assign out_load    = cur_valid_q && (!out_valid_q || out_ready_i);
  assign cur_free    = !cur_valid_q || (out_load && last);
  assign pop_ready_o = cur_free;

  // current byte and output word
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      cur_d.draw  = rest;
      out_valid_d = 1'b1;
      if (last) begin
        cur_valid_d = 1'b0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cur_free && pop_valid_i) begin
      cur_d       = pop_entry_i;
      cur_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (out_load) begin
      out_x_q     <= cur_q.x_base + pbsu_pkg::CoordW'(k_idx);
      out_y_q     <= cur_q.y;
      out_black_q <= cur_q.black[k_idx];
      out_bad_q   <= cur_q.bad;
      out_last_q  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_black_o = out_black_q;
  assign out_bad_o   = out_bad_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pbsu_checker.sv =====
// port-level checks of the unpacker and their binding to the top level
`default_nettype none

module pbsu_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        pready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata,
  input wire        m_axis_tuser,
  input wire        m_axis_tlast
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // a bad-configuration word is blank and alone for its byte
  a_bad_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 40'd0))
    else $error("bad configuration word not blank or not last");

  // pixels of one byte follow without gap on the same row
  a_byte_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && !m_axis_tuser &&
      (m_axis_tdata[33:17] == $past(m_axis_tdata[33:17])))
    else $error("pixels of one byte broken up");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind packed_bitmap_slice_unpacker pbsu_checker u_pbsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench of the packed bitmap slice unpacker: directed table, random phases, scoreboard
`default_nettype none

module tb;
  import pbsu_pkg::*;

  localparam int MaxRowBytes = 64;
  localparam int RandPhases  = 9;
  localparam int PhaseItems  = 27;
  localparam int DrainCycles = 20;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 200000;

  // mode codes that the package leaves out
  localparam logic [1:0] ModeOff = 2'd0;
  localparam logic [1:0] ModeBad = 2'd3;

  // one pixel word as the output carries it
  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic        black;
    logic        bad;
    logic        last;
  } pix_t;

  localparam pix_t BadPix = '{x: '0, y: '0, black: 1'b0, bad: 1'b1, last: 1'b1};

  // directed row: a register write or a byte, optionally with its word typed in
  typedef struct {
    bit          is_cfg;
    cfg_reg_e    reg_sel;
    logic [31:0] value;
    bit          typed;
    pix_t        want;
  } stim_row_t;

  typedef struct {
    bit   typed;
    pix_t want;
  } pin_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  wire  [ApbDataW-1:0] prdata;
  wire                 pready;
  logic                s_axis_tvalid;
  wire                 s_axis_tready;
  logic [7:0]          s_axis_tdata;
  wire                 m_axis_tvalid;
  logic                m_axis_tready;
  wire  [OutDataW-1:0] m_axis_tdata;
  wire                 m_axis_tuser;
  wire                 m_axis_tlast;

  packed_bitmap_slice_unpacker #(
    .MAX_ROW_BYTES(MaxRowBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // register mirror and row counters of the unpacker
  logic [7:0]  cfg_width  = '0;
  logic [7:0]  cfg_height = '0;
  logic [1:0]  cfg_mode   = '0;
  logic [7:0]  cfg_count  = '0;
  logic [7:0]  cfg_index  = '0;
  logic [15:0] cfg_org_x  = '0;
  logic [15:0] cfg_org_y  = '0;
  logic [5:0]  col_byte   = '0;
  logic [7:0]  cur_row    = '0;

  pix_t      pixel_q[$];
  pix_t      byte_pix[$];
  pin_t      pinned_q[$];
  stim_row_t stim_tab[$];

  int errors    = 0;
  int cycles    = 0;
  int hold_left = 0;
  bit hold_req  = 1'b0;
  bit idle_in   = 1'b0;
  bit idle_out  = 1'b0;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // pixel words that one byte draws, counters moved on
  function automatic void unpack_byte(input logic [7:0] b);
    int          stride;
    int          per_byte;
    int          col;
    bit          ok;
    bit          draw;
    bit          blk;
    logic [1:0]  pair;
    logic [16:0] ypos;
    pix_t        r;
    byte_pix.delete();
    stride = ((int'(cfg_width) + 7) / 8) * int'(cfg_mode);
    ok = (cfg_mode == Mode1Bpp || cfg_mode == Mode2Bpp) && cfg_width != 0 &&
         cfg_height != 0 && cfg_index < cfg_count && stride != 0 && stride <= MaxRowBytes;
    if (!ok) begin
      byte_pix.push_back(BadPix);
      return;
    end
    if (int'(col_byte) < stride) begin
      per_byte = (cfg_mode == Mode1Bpp) ? 8 : 4;
      ypos = {cfg_org_y[15], cfg_org_y} + 17'(cur_row);
      for (int k = 0; k < per_byte; k++) begin
        col = int'(col_byte) * per_byte + k;
        if (col >= int'(cfg_width)) break;
        if (cfg_mode == Mode1Bpp) begin
          draw = 1'b1;
          blk  = b[7-k];
        end else begin
          pair = b[(7-2*k) -: 2];
          draw = !pair[1];
          blk  = pair[0];
        end
        if (draw) begin
          r.x     = {cfg_org_x[15], cfg_org_x} + 17'(col);
          r.y     = ypos;
          r.black = blk;
          r.bad   = 1'b0;
          r.last  = 1'b0;
          byte_pix.push_back(r);
        end
      end
      if (byte_pix.size() > 0) byte_pix[byte_pix.size()-1].last = 1'b1;
    end
    // end of row, then end of slice
    if (int'(col_byte) + 1 >= stride) begin
      col_byte = '0;
      if (int'(cur_row) + 1 >= int'(cfg_height)) cur_row = '0;
      else cur_row = cur_row + 8'd1;
    end else begin
      col_byte = col_byte + 6'd1;
    end
  endfunction

  // mirror writes, predict accepted bytes, check pixel words
  always @(posedge clk_i) begin : scoreboard
    pin_t pin;
    pix_t got;
    pix_t want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[4:2]))
          REG_IMAGE_WIDTH:  cfg_width  = pwdata[7:0];
          REG_IMAGE_HEIGHT: cfg_height = pwdata[7:0];
          REG_PIXEL_MODE:   cfg_mode   = pwdata[1:0];
          REG_SLICE_COUNT:  cfg_count  = pwdata[7:0];
          REG_SLICE_INDEX:  cfg_index  = pwdata[7:0];
          REG_ORIGIN_X:     cfg_org_x  = pwdata[15:0];
          REG_ORIGIN_Y:     cfg_org_y  = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        unpack_byte(s_axis_tdata);
        pin.typed = 1'b0;
        if (pinned_q.size() > 0) pin = pinned_q.pop_front();
        if (pin.typed) pixel_q.push_back(pin.want);
        else foreach (byte_pix[i]) pixel_q.push_back(byte_pix[i]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x     = m_axis_tdata[16:0];
        got.y     = m_axis_tdata[33:17];
        got.black = m_axis_tdata[34];
        got.bad   = m_axis_tuser;
        got.last  = m_axis_tlast;
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel word x %0d y %0d", $signed(got.x), $signed(got.y));
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (got.x !== want.x) begin
            $error("pixel_x expected %0d got %0d", $signed(want.x), $signed(got.x));
            errors++;
          end
          if (got.y !== want.y) begin
            $error("pixel_y expected %0d got %0d", $signed(want.y), $signed(got.y));
            errors++;
          end
          if (got.black !== want.black) begin
            $error("pixel_black expected %0b got %0b", want.black, got.black);
            errors++;
          end
          if (got.bad !== want.bad) begin
            $error("bad_config expected %0b got %0b", want.bad, got.bad);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last_of_byte expected %0b got %0b", want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  // output side: random stalls and the long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_out && $urandom_range(0, 99) < 34);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_cfg(input cfg_reg_e r, input logic [31:0] v);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_sel = r;
    row.value   = v;
    row.typed   = 1'b0;
    row.want    = '0;
    stim_tab.push_back(row);
  endtask

  task automatic add_byte(input logic [7:0] d);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_sel = REG_IMAGE_WIDTH;
    row.value   = {24'd0, d};
    row.typed   = 1'b0;
    row.want    = '0;
    stim_tab.push_back(row);
  endtask

  task automatic add_typed(input logic [7:0] d, input pix_t w);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_sel = REG_IMAGE_WIDTH;
    row.value   = {24'd0, d};
    row.typed   = 1'b1;
    row.want    = w;
    stim_tab.push_back(row);
  endtask

  // setup phase, access phase until pready, then psel low again
  task automatic apb_write(input cfg_reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({r, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (idle_in && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 34);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and let every expected word drain out
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pixel_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] vals[7];
    int          widths[7];
    int          cnt;
    bit          busy;
    bit          noise;
    widths = '{8, 8, 2, 8, 8, 16, 16};
    busy   = 1'b0;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;

    // everything zero after reset: each byte is a config error
    add_typed(8'h00, BadPix);
    add_typed(8'hFF, BadPix);
    // one bit per pixel at the coordinate extremes
    add_cfg(REG_IMAGE_WIDTH, 32'd8);
    add_cfg(REG_IMAGE_HEIGHT, 32'd2);
    add_cfg(REG_PIXEL_MODE, 32'(Mode1Bpp));
    add_cfg(REG_SLICE_COUNT, 32'd1);
    add_cfg(REG_SLICE_INDEX, 32'd0);
    add_cfg(REG_ORIGIN_X, 32'h8000);
    add_cfg(REG_ORIGIN_Y, 32'h7FFF);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hA5);
    add_cfg(REG_ORIGIN_X, 32'h7FFF);
    add_cfg(REG_ORIGIN_Y, 32'h8000);
    add_byte(8'h5A);
    // columns past a narrow width draw nothing
    add_cfg(REG_IMAGE_WIDTH, 32'd3);
    add_byte(8'hFF);
    // two bits per pixel with transparent pairs
    add_cfg(REG_PIXEL_MODE, 32'(Mode2Bpp));
    add_cfg(REG_IMAGE_WIDTH, 32'd5);
    add_cfg(REG_IMAGE_HEIGHT, 32'd3);
    add_byte(8'h1B);
    add_byte(8'hAA);
    add_byte(8'h00);
    add_byte(8'hE4);
    // second byte of a one-pixel row lies wholly past the width
    add_cfg(REG_IMAGE_WIDTH, 32'd1);
    add_byte(8'h00);
    add_byte(8'h00);
    // widest row, then shrink it so the byte position is past the row
    add_cfg(REG_IMAGE_WIDTH, 32'd255);
    add_cfg(REG_IMAGE_HEIGHT, 32'd255);
    add_byte(8'h55);
    add_byte(8'h0F);
    add_byte(8'hF0);
    add_cfg(REG_PIXEL_MODE, 32'(Mode1Bpp));
    add_cfg(REG_IMAGE_WIDTH, 32'd8);
    add_byte(8'hFF);
    // row number left past a lowered height
    add_byte(8'h01);
    add_byte(8'h02);
    add_cfg(REG_IMAGE_HEIGHT, 32'd1);
    add_byte(8'h80);
    add_byte(8'h40);
    // invalid settings
    add_cfg(REG_SLICE_INDEX, 32'd1);
    add_typed(8'h33, BadPix);
    add_cfg(REG_SLICE_INDEX, 32'd0);
    add_cfg(REG_PIXEL_MODE, 32'(ModeBad));
    add_typed(8'hCC, BadPix);
    add_cfg(REG_PIXEL_MODE, 32'(Mode1Bpp));
    add_cfg(REG_IMAGE_HEIGHT, 32'd0);
    add_typed(8'h96, BadPix);
    add_cfg(REG_IMAGE_HEIGHT, 32'd1);
    add_cfg(REG_IMAGE_WIDTH, 32'd0);
    add_typed(8'h69, BadPix);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    idle_in  = 1'b1;
    idle_out = 1'b1;
    foreach (stim_tab[i]) begin
      if (stim_tab[i].is_cfg) begin
        if (busy) begin
          finish_phase();
          busy = 1'b0;
        end
        apb_write(stim_tab[i].reg_sel, stim_tab[i].value);
      end else begin
        pinned_q.push_back('{typed: stim_tab[i].typed, want: stim_tab[i].want});
        send_byte(stim_tab[i].value[7:0]);
        busy = 1'b1;
      end
    end
    if (busy) finish_phase();

    // random phases: first without idling, second under a long output hold-off
    for (int ph = 0; ph < RandPhases; ph++) begin
      idle_in  = (ph > 1);
      idle_out = (ph > 1);
      if (ph == RandPhases - 2) begin
        vals = '{16'd1, 16'd1, 16'(Mode1Bpp), 16'd1, 16'd0, 16'h8000, 16'h8000};
      end else if (ph == RandPhases - 1) begin
        vals = '{16'd255, 16'd255, 16'(Mode2Bpp), 16'd255, 16'd254, 16'h7FFF, 16'h7FFF};
      end else begin
        vals[0] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 255))
                                              : 16'($urandom_range(1, 20));
        vals[1] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 255))
                                              : 16'($urandom_range(1, 4));
        vals[2] = (ph == 1) ? 16'(Mode1Bpp) : 16'($urandom_range(1, 2));
        cnt     = $urandom_range(1, 255);
        vals[3] = 16'(cnt);
        vals[4] = 16'($urandom_range(0, cnt - 1));
        vals[5] = 16'($urandom);
        vals[6] = 16'($urandom);
        noise   = (ph > 1) && ($urandom_range(0, 2) == 0);
        if (noise) begin
          case ($urandom_range(0, 4))
            0: vals[2] = 16'(ModeOff);
            1: vals[2] = 16'(ModeBad);
            2: vals[0] = 16'd0;
            3: vals[1] = 16'd0;
            default: vals[4] = 16'($urandom_range(cnt, 255));
          endcase
        end
      end
      // junk above each field is dropped by the register
      for (int r = 0; r < 7; r++) begin
        apb_write(cfg_reg_e'(r), (32'($urandom) << widths[r]) | 32'(vals[r]));
      end
      if (ph == 1) hold_req = 1'b1;
      repeat (PhaseItems) send_byte(8'($urandom_range(0, 255)));
      finish_phase();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
